@@ design/femap_pkg.sv @@
// Shared types and codes for the free extent map allocator.
package femap_pkg;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic        action;
    logic [31:0] req_size;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    logic [31:0] alloc_address;
    logic [1:0]  status;
  } rsp_t;

  // What one cell loads at the next edge.
  typedef enum logic [1:0] {
    CTL_HOLD,
    CTL_RIGHT,
    CTL_LEFT,
    CTL_NEW
  } cell_ctl_t;

  // Operation broadcast along the row.
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_SHL,
    CMD_INS,
    CMD_WR
  } row_cmd_t;

endpackage

@@ design/femap_cell.sv @@
// One cell of the extent row: holds a start and a size, loads from a neighbour or the bus.
module femap_cell #(
  parameter int ADDR_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  femap_pkg::cell_ctl_t  ctl,
  input  logic [ADDR_BITS-1:0]  left_start,
  input  logic [ADDR_BITS-1:0]  left_size,
  input  logic [ADDR_BITS-1:0]  right_start,
  input  logic [ADDR_BITS-1:0]  right_size,
  input  logic [ADDR_BITS-1:0]  new_start,
  input  logic [ADDR_BITS-1:0]  new_size,
  output logic [ADDR_BITS-1:0]  start,
  output logic [ADDR_BITS-1:0]  size
);
  import femap_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      start <= '0;
      size  <= '0;
    end else begin
      case (ctl)
        CTL_RIGHT: begin
          start <= right_start;
          size  <= right_size;
        end
        CTL_LEFT: begin
          start <= left_start;
          size  <= left_size;
        end
        CTL_NEW: begin
          start <= new_start;
          size  <= new_size;
        end
        default: begin
          start <= start;
          size  <= size;
        end
      endcase
    end
  end

endmodule

@@ design/free_extent_map_allocator.sv @@
// Top level of the free extent map allocator: control sequencer and the row of extent cells.
//
//   channel  | handshake                | word
//   ---------+--------------------------+-------------------------------------
//   req      | req_valid / req_stall    | action, req_size, free_address
//   rsp      | rsp_valid / rsp_stall    | alloc_address, status
//   cfg      | cfg_wr_en                | cfg_wr_data -> next_fit
//
// One request is processed at a time. An allocate runs a fit search that
// reads one cell per cycle through a shared comparator, then S_AUPD
// updates the row. A free runs a scan from the first cell for the insert
// position, then up to three row updates for a double merge. Shifts move
// the whole row together, each cell loading from its neighbour. Reset
// (rst, synchronous) empties the row at once. A stalled response holds in
// the output register; the next request is taken but waits in S_DONE.
module free_extent_map_allocator #(
  parameter int MAP_ENTRIES = 64,
  parameter int ADDR_BITS   = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  femap_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output femap_pkg::rsp_t rsp,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data
);
  import femap_pkg::*;

  localparam int IW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int CW = $clog2(MAP_ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(MAP_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE, S_ASCAN, S_AUPD, S_FSCAN, S_FDEC, S_FMRG, S_FSHL, S_DONE
  } state_t;

  state_t state;

  logic [ADDR_BITS-1:0] cell_start [MAP_ENTRIES];
  logic [ADDR_BITS-1:0] cell_size  [MAP_ENTRIES];
  cell_ctl_t            cell_ctl   [MAP_ENTRIES];

  logic                 next_fit;
  logic [CW-1:0]        count;
  logic [CW-1:0]        rover;
  logic [CW-1:0]        ptr;
  logic [CW-1:0]        left;
  logic [ADDR_BITS-1:0] size_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [ADDR_BITS-1:0] hit_start;
  logic [ADDR_BITS-1:0] hit_size;
  logic [ADDR_BITS-1:0] prev_start;
  logic [ADDR_BITS-1:0] prev_size;
  logic                 has_prev;
  logic [ADDR_BITS-1:0] nx_start;
  logic [ADDR_BITS-1:0] nx_size;
  logic                 nx_valid;
  logic [ADDR_BITS-1:0] acc;
  logic [31:0]          res_addr;
  logic [1:0]           res_status;

  // Shared read port into the row.
  logic [IW-1:0]        rd_idx;
  logic [ADDR_BITS-1:0] rd_start;
  logic [ADDR_BITS-1:0] rd_size;

  // Row command for this cycle.
  row_cmd_t             cmd;
  logic [IW-1:0]        cmd_idx;
  logic [ADDR_BITS-1:0] cmd_start;
  logic [ADDR_BITS-1:0] cmd_size;

  logic [ADDR_BITS-1:0] free_end;
  logic [ADDR_BITS-1:0] prev_end;
  logic [ADDR_BITS-1:0] carve_size;
  logic [ADDR_BITS-1:0] carve_start;
  logic [ADDR_BITS:0]   sum_a;
  logic [ADDR_BITS:0]   sum_b;
  logic [ADDR_BITS-1:0] sat_a;
  logic [ADDR_BITS-1:0] sat_b;
  logic                 merge_prev;
  logic                 merge_next;
  logic [CW-1:0]        scan_from;

  assign rd_idx   = ptr[IW-1:0];
  assign rd_start = cell_start[rd_idx];
  assign rd_size  = cell_size[rd_idx];

  assign free_end    = addr_q + size_q;
  assign prev_end    = prev_start + prev_size;
  assign carve_size  = hit_size - size_q;
  assign carve_start = hit_start + size_q;

  assign merge_prev = has_prev && (addr_q == prev_end);
  assign merge_next = nx_valid && (free_end == nx_start);

  // Saturating sums: sat_a grows prev (or else the next extent) by the freed size; sat_b adds the next extent to it.
  assign sum_a = {1'b0, (merge_prev ? prev_size : nx_size)} + {1'b0, size_q};
  assign sat_a = sum_a[ADDR_BITS] ? '1 : sum_a[ADDR_BITS-1:0];
  assign sum_b = {1'b0, acc} + {1'b0, nx_size};
  assign sat_b = sum_b[ADDR_BITS] ? '1 : sum_b[ADDR_BITS-1:0];

  // Next fit starts at the rover, wrapping to zero at or past the table length; first fit starts at zero.
  always_comb begin
    scan_from = '0;
    if (next_fit) begin
      scan_from = (rover > count) ? count : rover;
    end
    if (scan_from == count) begin
      scan_from = '0;
    end
  end

  always_comb begin
    cmd       = CMD_NONE;
    cmd_idx   = rd_idx;
    cmd_start = carve_start;
    cmd_size  = carve_size;
    case (state)
      S_AUPD: begin
        cmd = (carve_size == '0) ? CMD_SHL : CMD_WR;
      end
      S_FDEC: begin
        if (merge_prev) begin
          cmd       = CMD_WR;
          cmd_idx   = rd_idx - IW'(1);
          cmd_start = prev_start;
          cmd_size  = sat_a;
        end else if (merge_next) begin
          cmd       = CMD_WR;
          cmd_start = addr_q;
          cmd_size  = sat_a;
        end else if (count != FULL) begin
          cmd       = CMD_INS;
          cmd_start = addr_q;
          cmd_size  = size_q;
        end
      end
      S_FMRG: begin
        cmd       = CMD_WR;
        cmd_idx   = rd_idx - IW'(1);
        cmd_start = prev_start;
        cmd_size  = sat_b;
      end
      S_FSHL: begin
        cmd = CMD_SHL;
      end
      default: begin
        cmd = CMD_NONE;
      end
    endcase
  end

  // Decode the broadcast command into one load select per cell.
  for (genvar i = 0; i < MAP_ENTRIES; i++) begin : g_row
    logic [ADDR_BITS-1:0] r_start;
    logic [ADDR_BITS-1:0] r_size;
    logic [ADDR_BITS-1:0] l_start;
    logic [ADDR_BITS-1:0] l_size;

    if (i == MAP_ENTRIES - 1) begin : g_last
      assign r_start = '0;
      assign r_size  = '0;
    end else begin : g_mid
      assign r_start = cell_start[i+1];
      assign r_size  = cell_size[i+1];
    end
    if (i == 0) begin : g_first
      assign l_start = '0;
      assign l_size  = '0;
    end else begin : g_rest
      assign l_start = cell_start[i-1];
      assign l_size  = cell_size[i-1];
    end

    always_comb begin
      cell_ctl[i] = CTL_HOLD;
      case (cmd)
        CMD_SHL: begin
          if (IW'(i) >= cmd_idx) cell_ctl[i] = CTL_RIGHT;
        end
        CMD_INS: begin
          if (IW'(i) == cmd_idx) cell_ctl[i] = CTL_NEW;
          else if (IW'(i) > cmd_idx) cell_ctl[i] = CTL_LEFT;
        end
        CMD_WR: begin
          if (IW'(i) == cmd_idx) cell_ctl[i] = CTL_NEW;
        end
        default: begin
          cell_ctl[i] = CTL_HOLD;
        end
      endcase
    end

    femap_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (cell_ctl[i]),
      .left_start  (l_start),
      .left_size   (l_size),
      .right_start (r_start),
      .right_size  (r_size),
      .new_start   (cmd_start),
      .new_size    (cmd_size),
      .start       (cell_start[i]),
      .size        (cell_size[i])
    );
  end

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      next_fit  <= 1'b0;
      count     <= '0;
      rover     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) next_fit <= cfg_wr_data;
      // Drop the response once taken, unless a new one loads this cycle.
      if (rsp_valid && !rsp_stall && state != S_DONE) rsp_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            size_q     <= ADDR_BITS'(req.req_size);
            addr_q     <= ADDR_BITS'(req.free_address);
            res_addr   <= '0;
            res_status <= ST_OK;
            has_prev   <= 1'b0;
            if (req.action == ACT_ALLOC) begin
              ptr  <= scan_from;
              left <= count;
              if (count == '0) begin
                res_status <= ST_NO_FIT;
                state      <= S_DONE;
              end else begin
                state <= S_ASCAN;
              end
            end else begin
              ptr   <= '0;
              // Drop a zero-size free.
              state <= (req.req_size == '0) ? S_DONE : S_FSCAN;
            end
          end
        end
        S_ASCAN: begin
          if (rd_size >= size_q) begin
            hit_start <= rd_start;
            hit_size  <= rd_size;
            state     <= S_AUPD;
          end else if (left == CW'(1)) begin
            res_status <= ST_NO_FIT;
            state      <= S_DONE;
          end else begin
            left <= left - CW'(1);
            ptr  <= (ptr + CW'(1) == count) ? '0 : ptr + CW'(1);
          end
        end
        S_AUPD: begin
          res_addr <= 32'(hit_start);
          if (carve_size == '0) begin
            count <= count - CW'(1);
            if (next_fit) rover <= ptr;
          end else if (next_fit) begin
            rover <= ptr + CW'(1);
          end
          state <= S_DONE;
        end
        S_FSCAN: begin
          if (ptr < count && rd_start <= addr_q) begin
            prev_start <= rd_start;
            prev_size  <= rd_size;
            has_prev   <= 1'b1;
            ptr        <= ptr + CW'(1);
          end else begin
            nx_valid <= (ptr < count);
            nx_start <= rd_start;
            nx_size  <= rd_size;
            state    <= S_FDEC;
          end
        end
        S_FDEC: begin
          acc   <= sat_a;
          state <= S_DONE;
          if (merge_prev) begin
            if (merge_next) state <= S_FMRG;
          end else if (!merge_next) begin
            if (count == FULL) res_status <= ST_FULL;
            else count <= count + CW'(1);
          end
        end
        S_FMRG: begin
          state <= S_FSHL;
        end
        S_FSHL: begin
          count <= count - CW'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          // Hold until the response register is free.
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid         <= 1'b1;
            rsp.alloc_address <= res_addr;
            rsp.status        <= res_status;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
